// File: src/mucf_pkg.sv
package mucf_pkg;

   localparam int MAX_VERTICES = 512;
   localparam int VTX_W = $clog2(MAX_VERTICES);
   localparam int CNT_W = VTX_W + 1;
   localparam int EPOCH_W = 16;

   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   typedef logic [VTX_W-1:0] vertex_type;
   typedef logic [CNT_W-1:0] count_type;
   typedef logic [EPOCH_W-1:0] epoch_type;

   typedef struct packed {
      logic op;
      vertex_type left_vertex;
      vertex_type first_partner;
      vertex_type second_partner;
   } req_word_type;

   typedef struct packed {
      vertex_type cycle_start;
      count_type cycle_length;
      logic is_last_cycle;
      logic exhausted;
      logic broken;
   } rsp_word_type;

endpackage

// File: src/mucf_if.sv
interface mucf_req_if;
   logic valid;
   logic ready;
   mucf_pkg::req_word_type word;

   modport source (output valid, output word, input ready);
   modport sink (input valid, input word, output ready);
endinterface

interface mucf_rsp_if;
   logic valid;
   logic ready;
   mucf_pkg::rsp_word_type word;

   modport source (output valid, output word, input ready);
   modport sink (input valid, input word, output ready);
endinterface

// File: src/matching_union_cycle_finder.sv
// A load word is written into the partner stores as it is accepted. A query word passes
// SCAN_RD and SCAN_CHK per visited vertex it skips, WALK_MARK and WALK_NEXT per left vertex
// on its cycle, then FINISH; one that finds no unvisited vertex goes from SCAN_RD to FINISH.
// Its result becomes valid as the input reopens; a result waiting on the output holds it shut.
// Synchronous active-high reset; afterwards all 512 entries of the visited store are swept,
// and again after every 65535 loads when the round mark wraps. No word is taken meanwhile.
module matching_union_cycle_finder (
   input logic clock,
   input logic reset,
   input logic csr_wr_en,
   input mucf_pkg::count_type csr_wr_data,
   mucf_req_if.sink req_ch,
   mucf_rsp_if.source rsp_ch
);
   import mucf_pkg::*;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SCAN_RD,
      ST_SCAN_CHK,
      ST_WALK_MARK,
      ST_WALK_NEXT,
      ST_FINISH
   } state_type;

   state_type state_ff;
   count_type active_size_ff;
   count_type n;
   count_type scan_ff;
   count_type count_ff;
   count_type len_ff;
   vertex_type start_ff;
   vertex_type l_ff;
   vertex_type clr_ff;
   epoch_type epoch_ff;
   rsp_word_type res_ff;
   rsp_word_type rsp_word_ff;
   logic rsp_valid_ff;

   vertex_type fm_mem [MAX_VERTICES];
   vertex_type si_mem [MAX_VERTICES];
   epoch_type ep_mem [MAX_VERTICES];

   logic fm_we, fm_re, si_we, si_re, ep_we, ep_re;
   vertex_type fm_waddr, fm_wdata, fm_raddr, fm_rdata_ff;
   vertex_type si_waddr, si_wdata, si_raddr, si_rdata_ff;
   vertex_type ep_waddr, ep_raddr;
   epoch_type ep_wdata, ep_rdata_ff;

   logic req_fire;
   logic rsp_load;
   logic visited_rd;
   logic mark;

   assign req_ch.ready = (state_ff == ST_IDLE);
   assign req_fire = req_ch.valid && req_ch.ready;
   assign rsp_ch.valid = rsp_valid_ff;
   assign rsp_ch.word = rsp_word_ff;
   assign rsp_load = (state_ff == ST_FINISH) && (!rsp_valid_ff || rsp_ch.ready);

   always_comb begin
      if (active_size_ff == '0) begin
         n = count_type'(1);
      end else if (active_size_ff > count_type'(MAX_VERTICES)) begin
         n = count_type'(MAX_VERTICES);
      end else begin
         n = active_size_ff;
      end
   end

   assign visited_rd = (ep_rdata_ff == epoch_ff);
   assign mark = ({1'b0, l_ff} < n) && !visited_rd;

   always_comb begin
      fm_we = 1'b0;
      fm_waddr = req_ch.word.left_vertex;
      fm_wdata = req_ch.word.first_partner;
      si_we = 1'b0;
      si_waddr = req_ch.word.second_partner;
      si_wdata = req_ch.word.left_vertex;
      fm_re = 1'b0;
      fm_raddr = scan_ff[VTX_W-1:0];
      si_re = 1'b0;
      si_raddr = fm_rdata_ff;
      ep_re = 1'b0;
      ep_raddr = scan_ff[VTX_W-1:0];
      ep_we = 1'b0;
      ep_waddr = l_ff;
      ep_wdata = epoch_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            ep_we = 1'b1;
            ep_waddr = clr_ff;
            ep_wdata = '0;
         end
         ST_IDLE: begin
            if (req_fire && req_ch.word.op == OP_LOAD) begin
               fm_we = 1'b1;
               si_we = 1'b1;
            end
         end
         ST_SCAN_RD: begin
            ep_re = (scan_ff < n);
         end
         ST_SCAN_CHK: begin
            if (!visited_rd) begin
               fm_re = 1'b1;
               ep_re = 1'b1;
            end
         end
         ST_WALK_MARK: begin
            si_re = 1'b1;
            ep_we = mark;
         end
         ST_WALK_NEXT: begin
            if (si_rdata_ff != start_ff && len_ff < n) begin
               fm_re = 1'b1;
               fm_raddr = si_rdata_ff;
               ep_re = 1'b1;
               ep_raddr = si_rdata_ff;
            end
         end
         ST_FINISH: begin
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (fm_we) begin
         fm_mem[fm_waddr] <= fm_wdata;
      end
      if (fm_re) begin
         fm_rdata_ff <= fm_mem[fm_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (si_we) begin
         si_mem[si_waddr] <= si_wdata;
      end
      if (si_re) begin
         si_rdata_ff <= si_mem[si_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (ep_we) begin
         ep_mem[ep_waddr] <= ep_wdata;
      end
      if (ep_re) begin
         ep_rdata_ff <= ep_mem[ep_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_size_ff <= count_type'(462);
      end else if (csr_wr_en) begin
         active_size_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_ff <= '0;
         epoch_ff <= epoch_type'(1);
         scan_ff <= '0;
         count_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_CLEAR: begin
               clr_ff <= clr_ff + vertex_type'(1);
               if (clr_ff == '1) begin
                  state_ff <= ST_IDLE;
               end
            end
            ST_IDLE: begin
               if (req_fire) begin
                  if (req_ch.word.op == OP_LOAD) begin
                     scan_ff <= '0;
                     count_ff <= '0;
                     if (epoch_ff == '1) begin
                        epoch_ff <= epoch_type'(1);
                        clr_ff <= '0;
                        state_ff <= ST_CLEAR;
                     end else begin
                        epoch_ff <= epoch_ff + epoch_type'(1);
                     end
                  end else begin
                     state_ff <= ST_SCAN_RD;
                  end
               end
            end
            ST_SCAN_RD: begin
               if (scan_ff >= n) begin
                  scan_ff <= n;
                  res_ff <= '{cycle_start: '0, cycle_length: '0, is_last_cycle: 1'b0,
                              exhausted: 1'b1, broken: 1'b0};
                  state_ff <= ST_FINISH;
               end else begin
                  state_ff <= ST_SCAN_CHK;
               end
            end
            ST_SCAN_CHK: begin
               if (visited_rd) begin
                  scan_ff <= scan_ff + count_type'(1);
                  state_ff <= ST_SCAN_RD;
               end else begin
                  start_ff <= scan_ff[VTX_W-1:0];
                  l_ff <= scan_ff[VTX_W-1:0];
                  len_ff <= '0;
                  state_ff <= ST_WALK_MARK;
               end
            end
            ST_WALK_MARK: begin
               len_ff <= len_ff + count_type'(1);
               if (mark) begin
                  count_ff <= count_ff + count_type'(1);
               end
               state_ff <= ST_WALK_NEXT;
            end
            ST_WALK_NEXT: begin
               if (si_rdata_ff == start_ff || len_ff >= n) begin
                  res_ff.cycle_start <= start_ff;
                  res_ff.cycle_length <= len_ff;
                  res_ff.is_last_cycle <= (count_ff >= n);
                  res_ff.exhausted <= 1'b0;
                  res_ff.broken <= (si_rdata_ff != start_ff);
                  scan_ff <= {1'b0, start_ff} + count_type'(1);
                  state_ff <= ST_FINISH;
               end else begin
                  l_ff <= si_rdata_ff;
                  state_ff <= ST_WALK_MARK;
               end
            end
            ST_FINISH: begin
               if (rsp_load) begin
                  rsp_word_ff <= res_ff;
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

endmodule
